// ===== sv/nppic_pkg.sv =====
// shared types and constants of the nearest parallel plane inlier counter
// no dependencies
package nppic_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD_NORMAL = 2'd0,
    FUNC_LOAD_OFFSET = 2'd1,
    FUNC_POINT       = 2'd2,
    FUNC_READ        = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_TRUNCATION   = 2'd0,
    CFG_PARALLEL_COS = 2'd1,
    CFG_SAMPLE_STRIDE = 2'd2,
    CFG_SETS_IN_USE  = 2'd3
  } cfg_e;

  typedef enum logic [9:0] {
    S_CLR  = 10'b00_0000_0001,
    S_IDLE = 10'b00_0000_0010,
    S_FAM  = 10'b00_0000_0100,
    S_PROD = 10'b00_0000_1000,
    S_ORD  = 10'b00_0001_0000,
    S_OEV  = 10'b00_0010_0000,
    S_FEND = 10'b00_0100_0000,
    S_CRD  = 10'b00_1000_0000,
    S_CWR  = 10'b01_0000_0000,
    S_RDC  = 10'b10_0000_0000
  } state_e;

  // one plane family as it travels along the cell chain
  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [6:0]         size;
  } fam_t;

  localparam logic [23:0] COUNT_MAX      = 24'hFFFFFF;
  localparam logic [30:0] TRUNC_RESET    = 31'd3277;
  localparam logic [14:0] PCOS_RESET     = 15'd15396;
  localparam logic [7:0]  STRIDE_RESET   = 8'd1;
  localparam logic [4:0]  SETS_RESET     = 5'd0;

endpackage

// ===== sv/nppic_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module nppic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/nppic_cell.sv =====
// one family cell: holds a family normal and size, joins the read chain
// depends on nppic_pkg
module nppic_cell
  import nppic_pkg::*;
#(
  parameter int IDX = 0,
  parameter int FW  = 4
) (
  input  logic          clk_i,
  input  logic          wr_i,
  input  logic [FW-1:0] wr_idx_i,
  input  fam_t          wr_data_i,
  input  logic [FW-1:0] sel_idx_i,
  input  fam_t          chain_i,
  output fam_t          chain_o
);

  fam_t fam_q;

  always_ff @(posedge clk_i) begin
    if (wr_i && (wr_idx_i == FW'(IDX))) begin
      fam_q <= wr_data_i;
    end
  end

  // pass the upstream value along, merged with ours when selected
  assign chain_o = (sel_idx_i == FW'(IDX)) ? (chain_i | fam_q) : chain_i;

endmodule

// ===== sv/nearest_parallel_plane_inlier_count.sv =====
// top level of the nearest parallel plane inlier counter
// depends on nppic_pkg, nppic_cell, nppic_ram
//
// channel   direction  handshake                  payload
// command   in         start_i, busy_o            func_i .. dir_z_i
// result    out        done_o (one cycle strobe)  inlier_o .. kept_o
// config    in         cfg_valid_i, cfg_ready_o   cfg_addr_i, cfg_data_i
//
// loads (func 0, 1) keep busy_o low and answer in the cycle after the accept
// a read holds busy_o high while in S_RDC and answers in the cycle after that
// a point holds busy_o through S_FAM, S_PROD and S_FEND for each family in use, with S_ORD and
// S_OEV for each offset read, plus S_CRD and S_CWR when it matches; done_o follows in the next cycle
// a skipped point or one with no family in use answers like a load
// after reset the count ram is cleared in S_CLR with busy_o high
// config is always ready; the receiver cannot stall results
module nearest_parallel_plane_inlier_count
  import nppic_pkg::*;
#(
  parameter int NUM_FAMILIES = 16,
  parameter int MAX_OFFSETS  = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         func_i,
  input  logic [3:0]         set_index_i,
  input  logic [5:0]         offset_index_i,
  input  logic [6:0]         offset_count_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_addr_i,
  input  logic [30:0]        cfg_data_i,
  output logic               done_o,
  output logic               inlier_o,
  output logic               skipped_o,
  output logic [3:0]         best_set_o,
  output logic [5:0]         best_offset_o,
  output logic signed [31:0] residual_o,
  output logic [23:0]        count_o,
  output logic               kept_o
);

  localparam int FW    = (NUM_FAMILIES > 1) ? $clog2(NUM_FAMILIES) : 1;
  localparam int UW    = $clog2(NUM_FAMILIES + 1);
  localparam int OW    = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;
  localparam int SW    = $clog2(MAX_OFFSETS + 1);
  localparam int DEPTH = NUM_FAMILIES * MAX_OFFSETS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [51:0] RES_MAX = 52'sh7FFFFFFF;
  localparam logic signed [51:0] RES_MIN = -RES_MAX - 52'sd1;

  // configuration registers
  logic [30:0] trunc_q;
  logic [14:0] pcos_q;
  logic [7:0]  stride_q;
  logic [4:0]  sets_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trunc_q  <= TRUNC_RESET;
      pcos_q   <= PCOS_RESET;
      stride_q <= STRIDE_RESET;
      sets_q   <= SETS_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_e'(cfg_addr_i))
        CFG_TRUNCATION:    trunc_q  <= cfg_data_i;
        CFG_PARALLEL_COS:  pcos_q   <= cfg_data_i[14:0];
        CFG_SAMPLE_STRIDE: stride_q <= cfg_data_i[7:0];
        CFG_SETS_IN_USE:   sets_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // control state
  state_e         state_q, state_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [7:0]     pos_q, pos_d;
  logic [FW-1:0]  fam_q, fam_d;
  logic [UW-1:0]  used_q, used_d;
  logic [SW-1:0]  off_q, off_d;
  logic           found_q, found_d;

  // datapath registers
  logic [SW-1:0]        size_q, size_d;
  logic signed [31:0]   px_q, py_q, pz_q;
  logic signed [15:0]   nx_q, ny_q, nz_q;
  logic signed [31:0]   pd0_q, pd1_q, pd2_q;
  logic signed [47:0]   pp0_q, pp1_q, pp2_q;
  logic signed [49:0]   np_q, np_d;
  logic signed [51:0]   cand_q, cand_d;
  logic [51:0]          cabs_q, cabs_d;
  logic [OW-1:0]        cj_q, cj_d;
  logic [51:0]          babs_q, babs_d;
  logic signed [51:0]   bres_q, bres_d;
  logic [FW-1:0]        bi_q, bi_d;
  logic [OW-1:0]        bj_q, bj_d;

  // result registers
  logic               done_q, done_d;
  logic               inl_q, inl_d;
  logic               skp_q, skp_d;
  logic [3:0]         bset_q, bset_d;
  logic [5:0]         boff_q, boff_d;
  logic signed [31:0] res_q, res_d;
  logic [23:0]        cnt_q, cnt_d;
  logic               kept_q, kept_d;

  // input decode
  logic accept, set_ok, slot_ok;
  assign accept  = start_i && !busy_o;
  assign set_ok  = int'(set_index_i) < NUM_FAMILIES;
  assign slot_ok = int'(offset_index_i) < MAX_OFFSETS;

  logic [AW-1:0] in_addr;
  assign in_addr = AW'(set_index_i) * AW'(MAX_OFFSETS) + AW'(offset_index_i);

  // family cell chain
  fam_t chain [NUM_FAMILIES+1];
  fam_t fam_wr;
  logic fam_we;

  assign chain[0] = '0;
  assign fam_we   = accept && (func_e'(func_i) == FUNC_LOAD_NORMAL) && set_ok;
  assign fam_wr   = '{nx: dir_x_i, ny: dir_y_i, nz: dir_z_i, size: offset_count_i};

  for (genvar g = 0; g < NUM_FAMILIES; g++) begin : g_cell
    nppic_cell #(
      .IDX(g),
      .FW (FW)
    ) u_cell (
      .clk_i    (clk_i),
      .wr_i     (fam_we),
      .wr_idx_i (FW'(set_index_i)),
      .wr_data_i(fam_wr),
      .sel_idx_i(fam_q),
      .chain_i  (chain[g]),
      .chain_o  (chain[g+1])
    );
  end

  fam_t cur;
  assign cur = chain[NUM_FAMILIES];

  // offset ram
  logic          off_we;
  logic [AW-1:0] off_raddr;
  logic [31:0]   off_rdata;

  assign off_we    = accept && (func_e'(func_i) == FUNC_LOAD_OFFSET) && set_ok && slot_ok;
  assign off_raddr = AW'(fam_q) * AW'(MAX_OFFSETS) + AW'(off_q);

  nppic_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_off_ram (
    .clk_i  (clk_i),
    .we_i   (off_we),
    .waddr_i(in_addr),
    .wdata_i(pos_x_i),
    .raddr_i(off_raddr),
    .rdata_o(off_rdata)
  );

  // count ram, cleared by a sweep after reset
  logic          cnt_we;
  logic [AW-1:0] cnt_waddr, cnt_raddr, best_addr;
  logic [23:0]   cnt_wdata, cnt_rdata;

  assign best_addr = AW'(bi_q) * AW'(MAX_OFFSETS) + AW'(bj_q);
  assign cnt_raddr = (state_q == S_IDLE) ? in_addr : best_addr;
  assign cnt_we    = (state_q == S_CLR) || (state_q == S_CWR);
  assign cnt_waddr = (state_q == S_CLR) ? clr_q : best_addr;
  assign cnt_wdata = (state_q == S_CLR) ? 24'd0 :
                     ((cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + 24'd1);

  nppic_ram #(
    .WIDTH(24),
    .DEPTH(DEPTH)
  ) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr),
    .rdata_o(cnt_rdata)
  );

  // stride position
  logic [7:0] stride_eff;
  logic [8:0] pos_inc;
  assign stride_eff = (stride_q == 8'd0) ? 8'd1 : stride_q;
  assign pos_inc    = 9'(pos_q) + 9'd1;

  // family test: normal dot and plane distance from registered products
  logic signed [33:0] dot;
  logic [33:0]        dot_abs;
  logic signed [49:0] np_sum;
  logic               fam_pass;
  assign dot      = 34'(pd0_q) + 34'(pd1_q) + 34'(pd2_q);
  assign dot_abs  = dot[33] ? 34'(-dot) : 34'(dot);
  assign np_sum   = 50'(pp0_q) + 50'(pp1_q) + 50'(pp2_q);
  assign fam_pass = (size_q != '0) && !(dot_abs < 34'({pcos_q, 14'd0}));

  // residual of the offset just read
  logic signed [51:0] r;
  logic [51:0]        r_abs;
  assign r     = 52'(np_q) + (52'($signed(off_rdata)) <<< 14);
  assign r_abs = r[51] ? 52'(-r) : 52'(r);

  // final residual, floor to Q16.16 with saturation
  logic signed [51:0] bres_sh;
  logic signed [31:0] res_sat;
  assign bres_sh = bres_q >>> 14;
  always_comb begin
    if (bres_sh > RES_MAX) begin
      res_sat = 32'sh7FFFFFFF;
    end else if (bres_sh < RES_MIN) begin
      res_sat = 32'sh80000000;
    end else begin
      res_sat = 32'(bres_sh);
    end
  end

  // family end: does the candidate beat the best so far
  logic better;
  assign better = cabs_q < babs_q;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    pos_d   = pos_q;
    fam_d   = fam_q;
    used_d  = used_q;
    off_d   = off_q;
    found_d = found_q;
    size_d  = size_q;
    np_d    = np_q;
    cand_d  = cand_q;
    cabs_d  = cabs_q;
    cj_d    = cj_q;
    babs_d  = babs_q;
    bres_d  = bres_q;
    bi_d    = bi_q;
    bj_d    = bj_q;
    done_d  = 1'b0;
    inl_d   = inl_q;
    skp_d   = skp_q;
    bset_d  = bset_q;
    boff_d  = boff_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    kept_d  = kept_q;

    case (state_q)
      S_CLR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          // default answer: all fields zero
          inl_d  = 1'b0;
          skp_d  = 1'b0;
          bset_d = '0;
          boff_d = '0;
          res_d  = '0;
          cnt_d  = '0;
          kept_d = 1'b0;
          case (func_e'(func_i))
            FUNC_POINT: begin
              pos_d  = (pos_inc >= 9'(stride_eff)) ? 8'd0 : pos_inc[7:0];
              used_d = (int'(sets_q) > NUM_FAMILIES) ? UW'(NUM_FAMILIES) : UW'(sets_q);
              if (pos_q != 8'd0) begin
                skp_d  = 1'b1;
                done_d = 1'b1;
              end else if (used_d == '0) begin
                done_d = 1'b1;
              end else begin
                fam_d   = '0;
                found_d = 1'b0;
                babs_d  = 52'({trunc_q, 14'd0});
                state_d = S_FAM;
              end
            end
            FUNC_READ: begin
              if (set_ok && slot_ok) begin
                state_d = S_RDC;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_FAM: begin
        size_d  = (int'(cur.size) > MAX_OFFSETS) ? SW'(MAX_OFFSETS) : SW'(cur.size);
        state_d = S_PROD;
      end

      S_PROD: begin
        if (fam_pass) begin
          np_d    = np_sum;
          off_d   = '0;
          state_d = S_ORD;
        end else begin
          // family passed over, no candidate
          cabs_d  = babs_q;
          state_d = S_FEND;
        end
      end

      S_ORD: begin
        state_d = S_OEV;
      end

      S_OEV: begin
        if ((off_q == '0) || (r_abs < cabs_q)) begin
          cand_d = r;
          cabs_d = r_abs;
          cj_d   = OW'(off_q);
          if (off_q + SW'(1) < size_q) begin
            off_d   = off_q + SW'(1);
            state_d = S_ORD;
          end else begin
            state_d = S_FEND;
          end
        end else begin
          state_d = S_FEND;
        end
      end

      S_FEND: begin
        if (better) begin
          babs_d  = cabs_q;
          bres_d  = cand_q;
          bi_d    = fam_q;
          bj_d    = cj_q;
          found_d = 1'b1;
        end
        if (UW'(fam_q) + UW'(1) < used_q) begin
          fam_d   = fam_q + FW'(1);
          state_d = S_FAM;
        end else if (found_d) begin
          state_d = S_CRD;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_CRD: begin
        state_d = S_CWR;
      end

      S_CWR: begin
        inl_d   = 1'b1;
        bset_d  = 4'(bi_q);
        boff_d  = 6'(bj_q);
        res_d   = res_sat;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_RDC: begin
        cnt_d   = cnt_rdata;
        kept_d  = cnt_rdata != 24'd0;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      pos_q   <= '0;
      fam_q   <= '0;
      used_q  <= '0;
      off_q   <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pos_q   <= pos_d;
      fam_q   <= fam_d;
      used_q  <= used_d;
      off_q   <= off_d;
      found_q <= found_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pz_q <= pos_z_i;
      nx_q <= dir_x_i;
      ny_q <= dir_y_i;
      nz_q <= dir_z_i;
    end
    if (state_q == S_FAM) begin
      pd0_q <= 32'($signed(cur.nx) * nx_q);
      pd1_q <= 32'($signed(cur.ny) * ny_q);
      pd2_q <= 32'($signed(cur.nz) * nz_q);
      pp0_q <= 48'($signed(cur.nx) * px_q);
      pp1_q <= 48'($signed(cur.ny) * py_q);
      pp2_q <= 48'($signed(cur.nz) * pz_q);
    end
    size_q <= size_d;
    np_q   <= np_d;
    cand_q <= cand_d;
    cabs_q <= cabs_d;
    cj_q   <= cj_d;
    babs_q <= babs_d;
    bres_q <= bres_d;
    bi_q   <= bi_d;
    bj_q   <= bj_d;
    inl_q  <= inl_d;
    skp_q  <= skp_d;
    bset_q <= bset_d;
    boff_q <= boff_d;
    res_q  <= res_d;
    cnt_q  <= cnt_d;
    kept_q <= kept_d;
  end

  assign busy_o        = state_q != S_IDLE;
  assign done_o        = done_q;
  assign inlier_o      = inl_q;
  assign skipped_o     = skp_q;
  assign best_set_o    = bset_q;
  assign best_offset_o = boff_q;
  assign residual_o    = res_q;
  assign count_o       = cnt_q;
  assign kept_o        = kept_q;

endmodule

// ===== sv/nppic_checker.sv =====
// port level checks of the nearest parallel plane inlier counter, bound to the top
// depends on nppic_pkg and nearest_parallel_plane_inlier_count
module nppic_checker
  import nppic_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [1:0]         func_i,
  input logic               done_o,
  input logic               inlier_o,
  input logic               skipped_o,
  input logic signed [31:0] residual_o,
  input logic [23:0]        count_o,
  input logic               kept_o
);

  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(inlier_o && skipped_o))
    else $error("inlier and skipped together");

  a_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (kept_o == (count_o != 24'd0)))
    else $error("kept does not follow count");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (func_i == FUNC_LOAD_NORMAL || func_i == FUNC_LOAD_OFFSET))
      |=> (done_o && !inlier_o && count_o == 24'd0))
    else $error("load transaction gave no clean answer");

  a_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && skipped_o) |-> (residual_o == 32'sd0 && count_o == 24'd0))
    else $error("skipped point carries data");

endmodule

bind nearest_parallel_plane_inlier_count nppic_checker u_nppic_checker (.*);
